FILE: design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table for the differential-drive
// odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // Number of CORDIC rotations; more than 32 is capped to the table size.
  localparam int CORDIC_STEPS = 24;
  localparam int CordicIters  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int StepW        = 5;
  localparam logic [StepW-1:0] StepLast = StepW'(CordicIters - 1);

  // CORDIC gain compensation, Q2.30.
  localparam logic signed [31:0] CordicGain = 32'sh26DD3B6A;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_CLEAR  = 1'b1
  } ddo_cmd_e;

  typedef enum logic {
    REG_DIST_PER_TICK  = 1'b0,
    REG_ANGLE_PER_TICK = 1'b1
  } ddo_reg_e;

  // Operand pairs for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_TURN = 2'd0,
    MUL_DIST = 2'd1,
    MUL_XCOS = 2'd2,
    MUL_YSIN = 2'd3
  } ddo_mul_e;

  typedef struct packed {
    logic               command;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [31:0] heading;
  } ddo_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             clear_pose;
    logic             mul_en;
    logic             mul_hi;
    ddo_mul_e         mul_sel;
    logic             head_add;
    logic             dist_cap;
    logic             cordic_init;
    logic             cordic_step;
    logic             cordic_fix;
    logic             x_add;
    logic             y_add;
    logic             out_load;
    logic [StepW-1:0] step;
  } ddo_ctrl_t;

  // atan(2^-i) as a binary angle, full turn = 2^32.
  function automatic logic [31:0] atan_lut(input logic [StepW-1:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: design/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Fixed-point pose integrator for a differential-drive base, driven by
// absolute wheel encoder counts.
// ----------------------------------------------------------------------------
// An update runs the two-pass shared multiplier, the CORDIC iterations of the
// shift-add unit and the pose accumulation before its pose is loaded; a clear
// goes straight to the output load. No new transaction is taken until the last
// one is in the output register, which waits while a result is still unread.
// Reset clears pose, stored counts and both configuration registers.
`default_nettype none

module differential_drive_odometry (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ddo_pkg::ddo_in_t   in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ddo_pkg::ddo_out_t       out_data_o
);

  ddo_pkg::ddo_ctrl_t ctrl;

  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_clear_i  (in_data_i.command == ddo_pkg::CMD_CLEAR),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  ddo_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_i     (ctrl),
    .out_data_o (out_data_o)
  );

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !(out_valid_o && !out_ready_i))
    else $error("result register overwritten while occupied");

  // The block is busy right after it takes a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Major datapath phases never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.load, ctrl.clear_pose, ctrl.cordic_init, ctrl.cordic_step,
              ctrl.cordic_fix, ctrl.out_load}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

FILE: design/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// Sequencer for the odometry datapath: multiplier passes, CORDIC iterations,
// pose accumulation and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_clear_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ddo_pkg::ddo_ctrl_t      ctrl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TURN_LO,
    S_TURN_HI,
    S_DIST_LO,
    S_DIST_HI,
    S_CINIT,
    S_CORDIC,
    S_FIX,
    S_XLO,
    S_XHI,
    S_YLO,
    S_YHI,
    S_YADD,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [ddo_pkg::StepW-1:0]    iter_q, iter_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    ctrl_o  = '0;
    ctrl_o.mul_sel = ddo_pkg::MUL_TURN;
    ctrl_o.step    = iter_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_clear_i) begin
            ctrl_o.clear_pose = 1'b1;
            state_d = S_DONE;
          end else begin
            ctrl_o.load = 1'b1;
            state_d = S_TURN_LO;
          end
        end
      end
      S_TURN_LO: begin
        ctrl_o.mul_en = 1'b1;
        state_d = S_TURN_HI;
      end
      S_TURN_HI: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_hi = 1'b1;
        state_d = S_DIST_LO;
      end
      S_DIST_LO: begin
        ctrl_o.head_add = 1'b1;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_sel  = ddo_pkg::MUL_DIST;
        state_d = S_DIST_HI;
      end
      S_DIST_HI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_hi  = 1'b1;
        ctrl_o.mul_sel = ddo_pkg::MUL_DIST;
        state_d = S_CINIT;
      end
      S_CINIT: begin
        ctrl_o.dist_cap    = 1'b1;
        ctrl_o.cordic_init = 1'b1;
        iter_d  = '0;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        ctrl_o.cordic_step = 1'b1;
        if (iter_q == ddo_pkg::StepLast) begin
          state_d = S_FIX;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      S_FIX: begin
        ctrl_o.cordic_fix = 1'b1;
        state_d = S_XLO;
      end
      S_XLO: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = ddo_pkg::MUL_XCOS;
        state_d = S_XHI;
      end
      S_XHI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_hi  = 1'b1;
        ctrl_o.mul_sel = ddo_pkg::MUL_XCOS;
        state_d = S_YLO;
      end
      S_YLO: begin
        ctrl_o.x_add   = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = ddo_pkg::MUL_YSIN;
        state_d = S_YHI;
      end
      S_YHI: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_hi  = 1'b1;
        ctrl_o.mul_sel = ddo_pkg::MUL_YSIN;
        state_d = S_YADD;
      end
      S_YADD: begin
        ctrl_o.y_add = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hand the pose to the output register once it is free.
        if (out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || ctrl_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ddo_dp.sv
// ----------------------------------------------------------------------------
// ddo_dp
// Odometry datapath: encoder deltas, a two-pass shared multiplier, a
// shift-add CORDIC unit, pose accumulators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ddo_pkg::ddo_in_t    in_data_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire ddo_pkg::ddo_ctrl_t  ctrl_i,
  output ddo_pkg::ddo_out_t        out_data_o
);

  // Configuration and architectural state.
  logic        [31:0] dist_tick_q, angle_tick_q;
  logic        [31:0] prev_left_q, prev_right_q;
  logic        [31:0] x_acc_q, y_acc_q, heading_q;

  // Working registers.
  logic signed [32:0] sum_q, diff_q;
  logic signed [61:0] prod_q, prod_d;
  logic signed [31:0] dist_q;
  logic signed [31:0] cx_q, cy_q, z_q;
  logic               quad_q;
  ddo_pkg::ddo_out_t  out_q;

  // Delta computation.
  logic signed [31:0] dl, dr;
  assign dl = signed'(in_data_i.left_count - prev_left_q);
  assign dr = signed'(in_data_i.right_count - prev_right_q);

  // Shared multiplier: 33-bit signed A times a 17-bit slice of 33-bit B.
  logic signed [32:0] a_op, b_op;
  logic signed [16:0] b_part;
  logic signed [49:0] partial;
  logic signed [61:0] partial_ext;

  always_comb begin
    unique case (ctrl_i.mul_sel)
      ddo_pkg::MUL_TURN: begin
        a_op = diff_q;
        b_op = signed'({1'b0, angle_tick_q});
      end
      ddo_pkg::MUL_DIST: begin
        a_op = sum_q;
        b_op = signed'({1'b0, dist_tick_q});
      end
      ddo_pkg::MUL_XCOS: begin
        a_op = 33'(dist_q);
        b_op = 33'(cx_q);
      end
      ddo_pkg::MUL_YSIN: begin
        a_op = 33'(dist_q);
        b_op = 33'(cy_q);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    b_part      = ctrl_i.mul_hi ? b_op[32:16] : signed'({1'b0, b_op[15:0]});
    partial     = a_op * b_part;
    partial_ext = 62'(partial);
    prod_d      = ctrl_i.mul_hi ? (prod_q + (partial_ext <<< 16)) : partial_ext;
  end

  // CORDIC rotation step.
  logic signed [31:0] dx, dy, atan_s;
  logic        [31:0] fold_sum;
  assign dx       = cy_q >>> ctrl_i.step;
  assign dy       = cx_q >>> ctrl_i.step;
  assign atan_s   = signed'(ddo_pkg::atan_lut(ctrl_i.step));
  assign fold_sum = heading_q + 32'h4000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_tick_q  <= '0;
      angle_tick_q <= '0;
      prev_left_q  <= '0;
      prev_right_q <= '0;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      heading_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ddo_pkg::REG_DIST_PER_TICK:  dist_tick_q  <= cfg_data_i;
          ddo_pkg::REG_ANGLE_PER_TICK: angle_tick_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.load) begin
        prev_left_q  <= in_data_i.left_count;
        prev_right_q <= in_data_i.right_count;
      end
      if (ctrl_i.clear_pose) begin
        x_acc_q   <= '0;
        y_acc_q   <= '0;
        heading_q <= '0;
      end else begin
        if (ctrl_i.head_add) heading_q <= heading_q + prod_q[31:0];
        if (ctrl_i.x_add)    x_acc_q   <= x_acc_q + prod_q[61:30];
        if (ctrl_i.y_add)    y_acc_q   <= y_acc_q + prod_q[61:30];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sum_q  <= 33'(dl) + 33'(dr);
      diff_q <= 33'(dr) - 33'(dl);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.dist_cap) begin
      dist_q <= signed'(prod_q[48:17]);
    end
    // Angles in the back half-plane are turned by half a turn and the
    // resulting vector is negated afterwards.
    if (ctrl_i.cordic_init) begin
      quad_q <= fold_sum[31];
      z_q    <= signed'(heading_q - {fold_sum[31], 31'd0});
      cx_q   <= ddo_pkg::CordicGain;
      cy_q   <= '0;
    end else if (ctrl_i.cordic_step) begin
      if (!z_q[31]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        z_q  <= z_q - atan_s;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        z_q  <= z_q + atan_s;
      end
    end else if (ctrl_i.cordic_fix && quad_q) begin
      cx_q <= -cx_q;
      cy_q <= -cy_q;
    end
    if (ctrl_i.out_load) begin
      out_q.pose_x  <= signed'(x_acc_q);
      out_q.pose_y  <= signed'(y_acc_q);
      out_q.heading <= heading_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
